[hw/rtl/usvg_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// usvg_pkg
// shared types, register codes and cordic constants of the sphere vertex
// generator
// ---------------------------------------------------------------------------
package usvg_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int MAX_COUNT     = 256;

	// pipeline stage positions
	localparam int P_JOB  = 0;
	localparam int P_MEM  = 1;
	localparam int P_FOLD = 2;
	localparam int P_CEND = P_FOLD + CORDIC_STAGES;
	localparam int P_MUL  = P_CEND + 1;
	localparam int P_SCL  = P_MUL + 1;
	localparam int P_OUT  = P_SCL + 1;
	localparam int NSTG   = P_OUT + 1;

	localparam logic [2:0] REG_RADIUS   = 3'd0;
	localparam logic [2:0] REG_BANDS    = 3'd1;
	localparam logic [2:0] REG_SEGMENTS = 3'd2;
	localparam logic [2:0] REG_VFOV     = 3'd3;
	localparam logic [2:0] REG_HFOV     = 3'd4;
	localparam logic [2:0] REG_MEDIA    = 3'd5;
	localparam logic [2:0] REG_ROTATION = 3'd6;

	localparam logic [1:0] MF_LEFT_RIGHT = 2'd1;
	localparam logic [1:0] MF_TOP_BOTTOM = 2'd2;

	localparam logic [2:0] ROT_0   = 3'd0;
	localparam logic [2:0] ROT_90  = 3'd1;
	localparam logic [2:0] ROT_180 = 3'd2;
	localparam logic [2:0] ROT_270 = 3'd3;

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic [31:0] ATAN_TAB [0:23] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004757,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81
	};

	typedef enum logic [1:0] {
		PC_LOAD,
		PC_DIV,
		PC_FILL,
		PC_DONE
	} pc_state_t;

	// texture and strip flags riding beside the cordic
	typedef struct packed {
		logic [15:0] u_left;
		logic [15:0] u_right;
		logic [15:0] v_left;
		logic [15:0] v_right;
		logic        deg;
		logic        last;
	} side_t;

endpackage

[hw/rtl/usvg_cordic.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// usvg_cordic
// pipelined rotation cordic: binary angle in, cosine and sine in Q30 out,
// one micro-rotation per stage after the load stage, each stage held by its own enable
// ---------------------------------------------------------------------------
module usvg_cordic (
	input  logic                                  clk,
	input  logic [usvg_pkg::CORDIC_STAGES:0]      en,
	input  logic [31:0]                           ang,
	output logic signed [31:0]                    cos_val,
	output logic signed [31:0]                    sin_val
);

	logic signed [33:0] xs_q [0:usvg_pkg::CORDIC_STAGES];
	logic signed [33:0] ys_q [0:usvg_pkg::CORDIC_STAGES];
	logic signed [33:0] zs_q [0:usvg_pkg::CORDIC_STAGES];
	logic               neg_q [0:usvg_pkg::CORDIC_STAGES];

	logic signed [33:0] z_in;
	logic signed [33:0] z_fold;
	logic               neg_in;

	// fold into [-90, 90] degrees, flip the result when folded
	always_comb begin
		z_in   = 34'($signed(ang));
		z_fold = z_in;
		neg_in = 1'b0;
		if (z_in > 34'sd1073741824) begin
			z_fold = z_in - 34'sd2147483648;
			neg_in = 1'b1;
		end else if (z_in < -34'sd1073741824) begin
			z_fold = z_in + 34'sd2147483648;
			neg_in = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			xs_q[0]  <= usvg_pkg::CORDIC_GAIN;
			ys_q[0]  <= '0;
			zs_q[0]  <= z_fold;
			neg_q[0] <= neg_in;
		end
	end

	for (genvar k = 0; k < usvg_pkg::CORDIC_STAGES; k++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en[k+1]) begin
				neg_q[k+1] <= neg_q[k];
				if (zs_q[k] >= 0) begin
					xs_q[k+1] <= xs_q[k] - (ys_q[k] >>> k);
					ys_q[k+1] <= ys_q[k] + (xs_q[k] >>> k);
					zs_q[k+1] <= zs_q[k] - $signed({2'b00, usvg_pkg::ATAN_TAB[k]});
				end else begin
					xs_q[k+1] <= xs_q[k] + (ys_q[k] >>> k);
					ys_q[k+1] <= ys_q[k] - (xs_q[k] >>> k);
					zs_q[k+1] <= zs_q[k] + $signed({2'b00, usvg_pkg::ATAN_TAB[k]});
				end
			end
		end
	end

	assign cos_val = neg_q[usvg_pkg::CORDIC_STAGES]
		? 32'(-xs_q[usvg_pkg::CORDIC_STAGES]) : 32'(xs_q[usvg_pkg::CORDIC_STAGES]);
	assign sin_val = neg_q[usvg_pkg::CORDIC_STAGES]
		? 32'(-ys_q[usvg_pkg::CORDIC_STAGES]) : 32'(ys_q[usvg_pkg::CORDIC_STAGES]);

endmodule

[hw/rtl/uv_sphere_vertex_generator.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uv_sphere_vertex_generator
// strip vertices of a partial uv sphere from (band, edge) index pairs
// ---------------------------------------------------------------------------
// The slave stream takes one (band, edge) word per handshake; the master
// stream gives its vertices in strip order, two per word, three on the
// first and on the last edge of a band, tlast on the final one.
// Registers are written through wr_en / wr_addr / wr_data while idle; the
// user must keep to this, the block itself does not enforce it. After reset
// and after every register write a sequencer divides the field of view and
// texture steps by the counts (eight serial divisions, each after an operand
// load) and then fills two 257-entry angle/texture tables, one entry per
// cycle, with s_axis_tready low all the while. Each vertex then runs through
// a 22-stage pipeline: job issue, table read, 17 cordic stages (sine and
// cosine of both angles side by side), product, radius scale and rotation
// select. One vertex leaves per cycle while m_axis_tready is high; a word
// gives two or three vertices, set by the vertex issue at the front.
// A stall on m_axis_tready holds the occupied stages; empty stages still
// fill, so words keep entering until the pipeline is full.
// ---------------------------------------------------------------------------
module uv_sphere_vertex_generator (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [2:0]   wr_addr,
	input  logic [15:0]  wr_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [23:0]  s_axis_tdata,  // band_index[7:0], edge_index[16:8], zero pad
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// pos_x, pos_y, pos_z, tex_u_left, tex_u_right, tex_v_left, tex_v_right, pad
	output logic [119:0] m_axis_tdata,
	output logic         m_axis_tuser,  // is_degenerate
	output logic         m_axis_tlast
);

	localparam int NS = usvg_pkg::NSTG;

	// configuration registers
	logic [15:0] radius_q;
	logic [8:0]  bands_q;
	logic [8:0]  segs_q;
	logic [14:0] vfov_q;
	logic [15:0] hfov_q;
	logic [1:0]  media_q;
	logic [2:0]  rot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 16'd256;
			bands_q  <= 9'd32;
			segs_q   <= 9'd64;
			vfov_q   <= 15'd18000;
			hfov_q   <= 16'd36000;
			media_q  <= 2'd0;
			rot_q    <= 3'd4;
		end else if (wr_en) begin
			unique case (wr_addr)
				usvg_pkg::REG_RADIUS:   radius_q <= wr_data;
				usvg_pkg::REG_BANDS:    bands_q  <= wr_data[8:0];
				usvg_pkg::REG_SEGMENTS: segs_q   <= wr_data[8:0];
				usvg_pkg::REG_VFOV:     vfov_q   <= wr_data[14:0];
				usvg_pkg::REG_HFOV:     hfov_q   <= wr_data;
				usvg_pkg::REG_MEDIA:    media_q  <= wr_data[1:0];
				usvg_pkg::REG_ROTATION: rot_q    <= wr_data[2:0];
				default: ;
			endcase
		end
	end

	// counts in use
	logic [8:0] nb;
	logic [8:0] ns;
	always_comb begin
		nb = bands_q;
		if (bands_q == 9'd0) nb = 9'd1;
		else if (bands_q > 9'(usvg_pkg::MAX_COUNT)) nb = 9'(usvg_pkg::MAX_COUNT);
		ns = segs_q;
		if (segs_q == 9'd0) ns = 9'd1;
		else if (segs_q > 9'(usvg_pkg::MAX_COUNT)) ns = 9'(usvg_pkg::MAX_COUNT);
	end

	// ------------------------------------------------------------------
	// table sequencer: streams 0..2 phi, t, h over bands; 3..5 theta, u,
	// half u over segments; divisions 6 and 7 give the angle offsets
	// ------------------------------------------------------------------
	usvg_pkg::pc_state_t pc_q, pc_next;
	logic [2:0]  div_q;
	logic [5:0]  bit_q;
	logic [8:0]  fa_q;
	logic [47:0] quo_q;
	logic [23:0] rem_q;
	logic [23:0] dvs_q;
	logic [31:0] qinc_q [0:5];
	logic [23:0] rinc_q [0:5];
	logic [31:0] acc_q  [0:5];
	logic [23:0] racc_q [0:5];
	logic [31:0] offv_q;
	logic [31:0] offh_q;

	logic [23:0] den [0:5];
	logic [47:0] dvd;
	logic [23:0] dvs;
	logic [24:0] trial;
	logic [24:0] diff;
	logic [47:0] quo_n;
	logic [23:0] rem_n;
	logic [31:0] acc_n  [0:5];
	logic [23:0] racc_n [0:5];
	logic [24:0] rsum;

	always_comb begin
		den[0] = 24'(nb) * 24'd36000;
		den[1] = 24'(nb);
		den[2] = 24'(nb);
		den[3] = 24'(ns) * 24'd36000;
		den[4] = 24'(ns);
		den[5] = 24'(ns);
		unique case (div_q)
			3'd0:    dvd = 48'(vfov_q) << 32;
			3'd1:    dvd = 48'd32768;
			3'd2:    dvd = 48'd16384;
			3'd3:    dvd = 48'(hfov_q) << 32;
			3'd4:    dvd = 48'd32768;
			3'd5:    dvd = 48'd16384;
			3'd6:    dvd = (48'(vfov_q) << 32) + 48'd36000;
			default: dvd = (48'(hfov_q) << 32) + 48'd36000;
		endcase
		dvs = (div_q >= 3'd6) ? 24'd72000 : den[div_q];
	end

	// one quotient bit per cycle
	always_comb begin
		trial = {rem_q, quo_q[47]};
		diff  = trial - {1'b0, dvs_q};
		if (trial >= {1'b0, dvs_q}) begin
			rem_n = diff[23:0];
			quo_n = {quo_q[46:0], 1'b1};
		end else begin
			rem_n = trial[23:0];
			quo_n = {quo_q[46:0], 1'b0};
		end
	end

	// running round(n * step / count): quotient plus exact remainder
	always_comb begin
		rsum = '0;
		for (int s = 0; s < 6; s++) begin
			rsum = {1'b0, racc_q[s]} + {1'b0, rinc_q[s]};
			acc_n[s] = acc_q[s] + qinc_q[s];
			racc_n[s] = rsum[23:0];
			if (rsum >= {1'b0, den[s]}) begin
				racc_n[s] = 24'(rsum - {1'b0, den[s]});
				acc_n[s]  = acc_q[s] + qinc_q[s] + 32'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pc_q <= usvg_pkg::PC_LOAD;
		else         pc_q <= pc_next;
	end

	always_comb begin
		pc_next = pc_q;
		unique case (pc_q)
			usvg_pkg::PC_LOAD: pc_next = usvg_pkg::PC_DIV;
			usvg_pkg::PC_DIV: begin
				if (bit_q == 6'd47)
					pc_next = (div_q == 3'd7) ? usvg_pkg::PC_FILL : usvg_pkg::PC_LOAD;
			end
			usvg_pkg::PC_FILL: begin
				if (fa_q == 9'(usvg_pkg::MAX_COUNT)) pc_next = usvg_pkg::PC_DONE;
			end
			usvg_pkg::PC_DONE: pc_next = usvg_pkg::PC_DONE;
			default: pc_next = usvg_pkg::PC_LOAD;
		endcase
		if (wr_en) pc_next = usvg_pkg::PC_LOAD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q <= '0;
			bit_q <= '0;
			fa_q  <= '0;
		end else if (wr_en) begin
			div_q <= '0;
		end else begin
			unique case (pc_q)
				usvg_pkg::PC_LOAD: bit_q <= '0;
				usvg_pkg::PC_DIV: begin
					bit_q <= bit_q + 6'd1;
					if (bit_q == 6'd47) begin
						div_q <= div_q + 3'd1;
						fa_q  <= '0;
					end
				end
				usvg_pkg::PC_FILL: fa_q <= fa_q + 9'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (pc_q)
			usvg_pkg::PC_LOAD: begin
				quo_q <= dvd;
				rem_q <= '0;
				dvs_q <= dvs;
			end
			usvg_pkg::PC_DIV: begin
				quo_q <= quo_n;
				rem_q <= rem_n;
				if (bit_q == 6'd47) begin
					if (div_q == 3'd6) begin
						offv_q <= quo_n[31:0];
					end else if (div_q == 3'd7) begin
						offh_q <= quo_n[31:0];
						for (int s = 0; s < 6; s++) begin
							acc_q[s]  <= '0;
							racc_q[s] <= den[s] >> 1;
						end
					end else begin
						qinc_q[div_q] <= quo_n[31:0];
						rinc_q[div_q] <= rem_n;
					end
				end
			end
			usvg_pkg::PC_FILL: begin
				for (int s = 0; s < 6; s++) begin
					acc_q[s]  <= acc_n[s];
					racc_q[s] <= racc_n[s];
				end
			end
			default: ;
		endcase
	end

	// band table: phi, t, h; segment table: theta, u, half u
	logic [63:0] band_mem [0:usvg_pkg::MAX_COUNT];
	logic [63:0] seg_mem  [0:usvg_pkg::MAX_COUNT];

	always_ff @(posedge clk) begin
		if (pc_q == usvg_pkg::PC_FILL) begin
			band_mem[fa_q] <= {acc_q[0] - offv_q, acc_q[1][15:0], acc_q[2][15:0]};
			seg_mem[fa_q]  <= {acc_q[3] + 32'h8000_0000 - offh_q,
				acc_q[4][15:0], acc_q[5][15:0]};
		end
	end

	// ------------------------------------------------------------------
	// pipeline control: a stage moves when it is empty or the next moves
	// ------------------------------------------------------------------
	logic [NS-1:0] vld_q;
	logic [NS-1:0] en;

	always_comb begin
		en[NS-1] = !vld_q[NS-1] || m_axis_tready;
		for (int k = NS - 2; k >= 0; k--) en[k] = !vld_q[k] || en[k+1];
	end

	// ------------------------------------------------------------------
	// vertex issue: two or three vertex jobs per word
	// ------------------------------------------------------------------
	logic       it_v_q;
	logic [7:0] it_j_q;
	logic [8:0] it_i_q;
	logic       it_first_q;
	logic       it_last_q;
	logic [1:0] cnt_q;

	logic [7:0] j_sat;
	logic [8:0] i_sat;
	logic [8:0] job_m;
	logic       job_deg;
	logic       job_last;
	logic       job_final;
	logic       issue;
	logic       accept;

	always_comb begin
		j_sat = s_axis_tdata[7:0];
		if (9'(s_axis_tdata[7:0]) > nb - 9'd1) j_sat = 8'(nb - 9'd1);
		i_sat = s_axis_tdata[16:8];
		if (s_axis_tdata[16:8] > ns) i_sat = ns;
	end

	always_comb begin
		job_m     = 9'(it_j_q);
		job_deg   = 1'b0;
		job_last  = 1'b0;
		job_final = 1'b0;
		priority if (it_first_q) begin
			// low, low copy, high
			job_deg = (cnt_q == 2'd1);
			if (cnt_q == 2'd2) begin
				job_m     = 9'(it_j_q) + 9'd1;
				job_last  = 1'b1;
				job_final = 1'b1;
			end
		end else if (it_last_q) begin
			// low, high, high copy
			if (cnt_q != 2'd0) job_m = 9'(it_j_q) + 9'd1;
			if (cnt_q == 2'd2) begin
				job_deg   = 1'b1;
				job_last  = 1'b1;
				job_final = 1'b1;
			end
		end else begin
			if (cnt_q != 2'd0) begin
				job_m     = 9'(it_j_q) + 9'd1;
				job_last  = 1'b1;
				job_final = 1'b1;
			end
		end
	end

	assign issue         = it_v_q && en[usvg_pkg::P_JOB];
	assign s_axis_tready = (pc_q == usvg_pkg::PC_DONE) && (!it_v_q || (issue && job_final));
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_v_q <= 1'b0;
			cnt_q  <= '0;
		end else if (accept) begin
			it_v_q <= 1'b1;
			cnt_q  <= '0;
		end else if (issue) begin
			if (job_final) it_v_q <= 1'b0;
			else           cnt_q  <= cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			it_j_q     <= j_sat;
			it_i_q     <= i_sat;
			it_first_q <= (i_sat == 9'd0);
			it_last_q  <= (i_sat == ns);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= issue;
			for (int k = 1; k < NS; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// job register
	logic [8:0] m_s1;
	logic [8:0] i_s1;
	logic       deg_s1;
	logic       last_s1;

	always_ff @(posedge clk) begin
		if (en[usvg_pkg::P_JOB]) begin
			m_s1    <= job_m;
			i_s1    <= it_i_q;
			deg_s1  <= job_deg;
			last_s1 <= job_last;
		end
	end

	// table read
	logic [63:0] bw_s2;
	logic [63:0] sw_s2;
	logic        deg_s2;
	logic        last_s2;

	always_ff @(posedge clk) begin
		if (en[usvg_pkg::P_MEM]) begin
			bw_s2   <= band_mem[m_s1];
			sw_s2   <= seg_mem[i_s1];
			deg_s2  <= deg_s1;
			last_s2 <= last_s1;
		end
	end

	// texture coordinates, carried beside the cordic
	usvg_pkg::side_t side_in;
	usvg_pkg::side_t sb_q [usvg_pkg::P_FOLD:usvg_pkg::P_OUT];

	always_comb begin
		side_in.deg  = deg_s2;
		side_in.last = last_s2;
		if (media_q == usvg_pkg::MF_LEFT_RIGHT) begin
			side_in.u_left  = sw_s2[15:0];
			side_in.u_right = sw_s2[15:0] + 16'd16384;
		end else begin
			side_in.u_left  = sw_s2[31:16];
			side_in.u_right = sw_s2[31:16];
		end
		if (media_q == usvg_pkg::MF_TOP_BOTTOM) begin
			side_in.v_left  = 16'd16384 - bw_s2[15:0];
			side_in.v_right = 16'd32768 - bw_s2[15:0];
		end else begin
			side_in.v_left  = 16'd32768 - bw_s2[31:16];
			side_in.v_right = 16'd32768 - bw_s2[31:16];
		end
	end

	always_ff @(posedge clk) begin
		if (en[usvg_pkg::P_FOLD]) sb_q[usvg_pkg::P_FOLD] <= side_in;
		for (int k = usvg_pkg::P_FOLD + 1; k <= usvg_pkg::P_OUT; k++) begin
			if (en[k]) sb_q[k] <= sb_q[k-1];
		end
	end

	// sine and cosine of latitude and longitude
	logic signed [31:0] cp, sp, ct, st;

	usvg_cordic u_cordic_phi (
		.clk     (clk),
		.en      (en[usvg_pkg::P_CEND:usvg_pkg::P_FOLD]),
		.ang     (bw_s2[63:32]),
		.cos_val (cp),
		.sin_val (sp)
	);

	usvg_cordic u_cordic_theta (
		.clk     (clk),
		.en      (en[usvg_pkg::P_CEND:usvg_pkg::P_FOLD]),
		.ang     (sw_s2[63:32]),
		.cos_val (ct),
		.sin_val (st)
	);

	// Q30 products
	logic signed [63:0] pcc;
	logic signed [63:0] psc;
	logic signed [31:0] cc_q;
	logic signed [31:0] sc_q;
	logic signed [31:0] sp_q;

	assign pcc = 64'(ct) * 64'(cp) + 64'sd536870912;
	assign psc = 64'(st) * 64'(cp) + 64'sd536870912;

	always_ff @(posedge clk) begin
		if (en[usvg_pkg::P_MUL]) begin
			cc_q <= pcc[61:30];
			sc_q <= psc[61:30];
			sp_q <= sp;
		end
	end

	function automatic logic signed [16:0] scale_r(input logic [15:0] r,
		input logic signed [31:0] q);
		logic signed [48:0] p;
		logic signed [18:0] v;
		p = 49'($signed({1'b0, r})) * 49'(q) + 49'sd536870912;
		v = p[48:30];
		if (v > 19'sd65535)       scale_r = 17'sd65535;
		else if (v < -19'sd65535) scale_r = -17'sd65535;
		else                      scale_r = v[16:0];
	endfunction

	// radius scale
	logic signed [16:0] rcc_q;
	logic signed [16:0] rsc_q;
	logic signed [16:0] rsp_q;

	always_ff @(posedge clk) begin
		if (en[usvg_pkg::P_SCL]) begin
			rcc_q <= scale_r(radius_q, cc_q);
			rsc_q <= scale_r(radius_q, sc_q);
			rsp_q <= scale_r(radius_q, sp_q);
		end
	end

	// rotation select into the output word
	logic signed [16:0] px_q, py_q, pz_q;

	always_ff @(posedge clk) begin
		if (en[usvg_pkg::P_OUT]) begin
			unique case (rot_q)
				usvg_pkg::ROT_0: begin
					px_q <= rcc_q;  py_q <= rsc_q;  pz_q <= -rsp_q;
				end
				usvg_pkg::ROT_90: begin
					px_q <= -rsc_q; py_q <= -rcc_q; pz_q <= -rsp_q;
				end
				usvg_pkg::ROT_180: begin
					px_q <= rcc_q;  py_q <= -rsc_q; pz_q <= -rsp_q;
				end
				usvg_pkg::ROT_270: begin
					px_q <= -rsc_q; py_q <= rcc_q;  pz_q <= -rsp_q;
				end
				default: begin
					px_q <= -rsc_q; py_q <= rsp_q;  pz_q <= rcc_q;
				end
			endcase
		end
	end

	assign m_axis_tvalid = vld_q[usvg_pkg::P_OUT];
	assign m_axis_tdata  = {5'd0,
		sb_q[usvg_pkg::P_OUT].v_right, sb_q[usvg_pkg::P_OUT].v_left,
		sb_q[usvg_pkg::P_OUT].u_right, sb_q[usvg_pkg::P_OUT].u_left,
		pz_q, py_q, px_q};
	assign m_axis_tuser  = sb_q[usvg_pkg::P_OUT].deg;
	assign m_axis_tlast  = sb_q[usvg_pkg::P_OUT].last;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	a_ready_tables: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> pc_q == usvg_pkg::PC_DONE)
		else $error("word taken while tables are being built");

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && job_final && !accept) |=> !it_v_q)
		else $error("word still held after its final vertex");

	a_middle_two: assert property (@(posedge clk) disable iff (!arst_n)
		(it_v_q && !it_first_q && !it_last_q) |-> cnt_q <= 2'd1)
		else $error("inner edge issued more than two vertices");

	a_job_valid: assert property (@(posedge clk) disable iff (!arst_n)
		issue |=> vld_q[usvg_pkg::P_JOB])
		else $error("issued vertex job lost");

endmodule

[tb/sv/vertex_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vertex_checker
// Watches the register port and both streams of the sphere vertex generator.
// It keeps its own copy of the registers and computes the strip vertices
// of every accepted (band, edge) word: cordic sine/cosine, radius scaling,
// rotation and texture coordinates. Each vertex word that leaves the block
// is compared field by field with the oldest expected vertex.
// ---------------------------------------------------------------------------
module vertex_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [2:0]   wr_addr,
	input  logic [15:0]  wr_data,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [23:0]  s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [119:0] m_axis_tdata,
	input  logic         m_axis_tuser,
	input  logic         m_axis_tlast,
	output int           fail_count,
	output int           vertices_pending
);

	typedef struct {
		logic signed [16:0] x;
		logic signed [16:0] y;
		logic signed [16:0] z;
		logic [15:0]        ul;
		logic [15:0]        ur;
		logic [15:0]        vl;
		logic [15:0]        vr;
		logic               deg;
		logic               last;
	} vertex_t;

	vertex_t expected_vertices[$];

	logic [15:0] radius;
	logic [8:0]  band_count;
	logic [8:0]  segment_count;
	logic [14:0] vfov;
	logic [15:0] hfov;
	logic [1:0]  media;
	logic [2:0]  rotation;

	localparam longint unsigned FULL_TURN = 64'd1 << 32;
	localparam longint          HALF_Q30  = 64'sd1 << 29;

	function automatic longint unsigned round_div(longint unsigned n, longint unsigned d);
		return (n + d / 2) / d;
	endfunction

	// cos and sin in Q30 of a binary angle
	function automatic void cordic_sincos(input logic [31:0] ang, output longint c,
			output longint s);
		longint z, x, y, nx;
		bit     neg;
		z = ang[31] ? longint'(ang) - longint'(FULL_TURN) : longint'(ang);
		x = usvg_pkg::CORDIC_GAIN;
		y = 0;
		neg = 0;
		if (z > (64'sd1 << 30)) begin
			z -= 64'sd1 << 31;
			neg = 1;
		end else if (z < -(64'sd1 << 30)) begin
			z += 64'sd1 << 31;
			neg = 1;
		end
		for (int k = 0; k < usvg_pkg::CORDIC_STAGES && k < 24; k++) begin
			if (z >= 0) begin
				nx = x - (y >>> k);
				y = y + (x >>> k);
				z -= longint'(usvg_pkg::ATAN_TAB[k]);
			end else begin
				nx = x + (y >>> k);
				y = y - (x >>> k);
				z += longint'(usvg_pkg::ATAN_TAB[k]);
			end
			x = nx;
		end
		c = neg ? -x : x;
		s = neg ? -y : y;
	endfunction

	function automatic longint scale_radius(longint q);
		longint v;
		v = (longint'(radius) * q + HALF_Q30) >>> 30;
		if (v > 65535) v = 65535;
		if (v < -65535) v = -65535;
		return v;
	endfunction

	function automatic vertex_t strip_vertex(longint unsigned j, longint unsigned k,
			longint unsigned i, longint unsigned nb, longint unsigned ns);
		vertex_t v;
		longint unsigned m, phi, th, h, t;
		longint ct, st, cp, sp, cc, sc, rsp;
		m = j + k;
		phi = round_div(vfov * m * FULL_TURN, 36000 * nb)
			- round_div(vfov * FULL_TURN, 72000);
		th = round_div(hfov * i * FULL_TURN, 36000 * ns) + (64'd1 << 31)
			- round_div(hfov * FULL_TURN, 72000);
		cordic_sincos(phi[31:0], cp, sp);
		cordic_sincos(th[31:0], ct, st);
		cc = scale_radius((ct * cp + HALF_Q30) >>> 30);
		sc = scale_radius((st * cp + HALF_Q30) >>> 30);
		rsp = scale_radius(sp);
		case (rotation)
			usvg_pkg::ROT_0: begin
				v.x = cc; v.y = sc; v.z = -rsp;
			end
			usvg_pkg::ROT_90: begin
				v.x = -sc; v.y = -cc; v.z = -rsp;
			end
			usvg_pkg::ROT_180: begin
				v.x = cc; v.y = -sc; v.z = -rsp;
			end
			usvg_pkg::ROT_270: begin
				v.x = -sc; v.y = cc; v.z = -rsp;
			end
			default: begin
				v.x = -sc; v.y = rsp; v.z = cc;
			end
		endcase
		if (media == usvg_pkg::MF_LEFT_RIGHT) begin
			v.ul = round_div(i * 16384, ns);
			v.ur = v.ul + 16'd16384;
		end else begin
			v.ul = round_div(i * 32768, ns);
			v.ur = v.ul;
		end
		if (media == usvg_pkg::MF_TOP_BOTTOM) begin
			h = round_div(m * 16384, nb);
			v.vl = 16384 - h;
			v.vr = 32768 - h;
		end else begin
			t = round_div(m * 32768, nb);
			v.vl = 32768 - t;
			v.vr = v.vl;
		end
		v.deg = 0;
		v.last = 0;
		return v;
	endfunction

	task automatic predict_word(logic [7:0] band, logic [8:0] edge_idx);
		longint unsigned nb, ns, j, i;
		vertex_t lo, hi;
		nb = band_count;
		ns = segment_count;
		if (nb < 1) nb = 1;
		if (nb > usvg_pkg::MAX_COUNT) nb = usvg_pkg::MAX_COUNT;
		if (ns < 1) ns = 1;
		if (ns > usvg_pkg::MAX_COUNT) ns = usvg_pkg::MAX_COUNT;
		j = band;
		i = edge_idx;
		if (j > nb - 1) j = nb - 1;
		if (i > ns) i = ns;
		lo = strip_vertex(j, 0, i, nb, ns);
		hi = strip_vertex(j, 1, i, nb, ns);
		expected_vertices.push_back(lo);
		if (i == 0) begin
			lo.deg = 1;
			expected_vertices.push_back(lo);
		end
		// on the last edge the high copy closes the word
		hi.last = (i != ns);
		expected_vertices.push_back(hi);
		if (i == ns) begin
			hi.deg = 1;
			hi.last = 1;
			expected_vertices.push_back(hi);
		end
	endtask

	task automatic report(string what, longint got, longint want);
		$display("%0t: vertex %s is %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	task automatic compare_word();
		vertex_t e;
		if (expected_vertices.size() == 0) begin
			report("word with nothing pending, tlast", m_axis_tlast, 0);
			return;
		end
		e = expected_vertices.pop_front();
		if (m_axis_tdata[16:0] !== e.x)
			report("pos_x", $signed(m_axis_tdata[16:0]), e.x);
		if (m_axis_tdata[33:17] !== e.y)
			report("pos_y", $signed(m_axis_tdata[33:17]), e.y);
		if (m_axis_tdata[50:34] !== e.z)
			report("pos_z", $signed(m_axis_tdata[50:34]), e.z);
		if (m_axis_tdata[66:51] !== e.ul) report("tex_u_left", m_axis_tdata[66:51], e.ul);
		if (m_axis_tdata[82:67] !== e.ur) report("tex_u_right", m_axis_tdata[82:67], e.ur);
		if (m_axis_tdata[98:83] !== e.vl) report("tex_v_left", m_axis_tdata[98:83], e.vl);
		if (m_axis_tdata[114:99] !== e.vr) report("tex_v_right", m_axis_tdata[114:99], e.vr);
		if (m_axis_tuser !== e.deg) report("is_degenerate", m_axis_tuser, e.deg);
		if (m_axis_tlast !== e.last) report("last_of_item", m_axis_tlast, e.last);
	endtask

	initial begin
		fail_count = 0;
		vertices_pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius <= 16'd256;
			band_count <= 9'd32;
			segment_count <= 9'd64;
			vfov <= 15'd18000;
			hfov <= 16'd36000;
			media <= 2'd0;
			rotation <= 3'd4;
			expected_vertices.delete();
			vertices_pending <= 0;
		end else begin
			if (wr_en) begin
				case (wr_addr)
					usvg_pkg::REG_RADIUS:   radius <= wr_data;
					usvg_pkg::REG_BANDS:    band_count <= wr_data[8:0];
					usvg_pkg::REG_SEGMENTS: segment_count <= wr_data[8:0];
					usvg_pkg::REG_VFOV:     vfov <= wr_data[14:0];
					usvg_pkg::REG_HFOV:     hfov <= wr_data;
					usvg_pkg::REG_MEDIA:    media <= wr_data[1:0];
					usvg_pkg::REG_ROTATION: rotation <= wr_data[2:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_word(s_axis_tdata[7:0], s_axis_tdata[16:8]);
			if (m_axis_tvalid && m_axis_tready)
				compare_word();
			vertices_pending <= expected_vertices.size();
		end
	end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the sphere vertex generator. A directed set of
// index pairs at reset settings is followed by register phases covering
// the count, field of view, media and rotation extremes, each with random
// index pairs sent in bursts while the vertex stream stalls at random.
// ---------------------------------------------------------------------------
module testbench;

	localparam int PHASES = 7;

	logic         clk;
	logic         arst_n;
	logic         wr_en;
	logic [2:0]   wr_addr;
	logic [15:0]  wr_data;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [23:0]  s_axis_tdata;   // band_index, edge_index, pad
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [119:0] m_axis_tdata;   // pos_x, pos_y, pos_z, u_left, u_right, v_left, v_right
	logic         m_axis_tuser;   // is_degenerate
	logic         m_axis_tlast;
	int           fail_count;
	int           vertices_pending;

	int burst_left;
	int band_limit;
	int seg_limit;

	// per phase: radius, bands, segments, vfov, hfov, media, rotation
	int phase_regs [PHASES][7] = '{
		'{65535,   1,   1, 18000, 36000, 1, 0},
		'{    1, 256, 256,     1,     1, 2, 1},
		'{40000,   0,   0, 32767, 65535, 3, 2},
		'{  300, 511, 300,     0,     0, 0, 3},
		'{65535,   7,   5,  9000, 18000, 2, 5},
		'{12345, 100, 200, 12000, 24000, 1, 7},
		'{  256,  32,  64, 18000, 36000, 0, 4}
	};

	uv_sphere_vertex_generator dut (.*);

	vertex_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end

	// vertex stream stalls: runs of full rate, random and mostly stalled
	initial begin
		int mode, left;
		m_axis_tready = 0;
		mode = 0;
		left = 0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 2);
				left = $urandom_range(5, 60);
			end
			left--;
			case (mode)
				0: m_axis_tready <= 1;
				1: m_axis_tready <= $urandom_range(0, 1);
				default: m_axis_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// leaves the write enable high; the caller drops it after the last write
	task automatic write_reg(logic [2:0] addr, int value);
		wr_en <= 1;
		wr_addr <= addr;
		wr_data <= 16'(value);
		@(negedge clk);
	endtask

	// called at a falling edge, returns at a falling edge
	task automatic send_word(int band, int edge_idx);
		int gap;
		s_axis_tvalid <= 1;
		s_axis_tdata <= {7'd0, edge_idx[8:0], band[7:0]};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 8);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	task automatic random_word();
		int band, edge_idx;
		band = ($urandom_range(0, 9) < 7) ? $urandom_range(0, band_limit - 1)
			: $urandom_range(0, 255);
		case ($urandom_range(0, 5))
			0: edge_idx = 0;
			1: edge_idx = seg_limit;
			2: edge_idx = $urandom_range(0, 511);
			default: edge_idx = $urandom_range(0, seg_limit);
		endcase
		send_word(band, edge_idx);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (vertices_pending != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	initial begin
		arst_n = 0;
		wr_en = 0;
		wr_addr = usvg_pkg::REG_RADIUS;
		wr_data = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		burst_left = 0;
		repeat (6) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed words at reset settings: 32 bands, 64 segments
		send_word(0, 0);
		send_word(0, 1);
		send_word(0, 64);
		send_word(31, 0);
		send_word(31, 64);
		send_word(31, 63);
		send_word(255, 511);
		send_word(128, 256);
		send_word(32, 65);
		send_word(170, 341);
		send_word(85, 170);
		send_word(16, 32);
		send_word(1, 2);
		s_axis_tvalid <= 0;
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			write_reg(usvg_pkg::REG_RADIUS, phase_regs[p][0]);
			write_reg(usvg_pkg::REG_BANDS, phase_regs[p][1]);
			write_reg(usvg_pkg::REG_SEGMENTS, phase_regs[p][2]);
			write_reg(usvg_pkg::REG_VFOV, phase_regs[p][3]);
			write_reg(usvg_pkg::REG_HFOV, phase_regs[p][4]);
			write_reg(usvg_pkg::REG_MEDIA, phase_regs[p][5]);
			write_reg(usvg_pkg::REG_ROTATION, phase_regs[p][6]);
			wr_en <= 0;
			band_limit = phase_regs[p][1];
			seg_limit = phase_regs[p][2];
			if (band_limit < 1) band_limit = 1;
			if (band_limit > usvg_pkg::MAX_COUNT) band_limit = usvg_pkg::MAX_COUNT;
			if (seg_limit < 1) seg_limit = 1;
			if (seg_limit > usvg_pkg::MAX_COUNT) seg_limit = usvg_pkg::MAX_COUNT;
			repeat (27) random_word();
			s_axis_tvalid <= 0;
			wait_drained();
		end

		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/usvg_pkg.sv
hw/rtl/usvg_cordic.sv
hw/rtl/uv_sphere_vertex_generator.sv
tb/sv/vertex_checker.sv
tb/sv/testbench.sv
